// ===== hw/rtl/ipl_pkg.sv =====
// Shared constants, action codes and control types for the ID pool LRU table.
package ipl_pkg;

  localparam int DEF_POOL_ENTRIES = 16;
  localparam int DEF_ID_BITS      = 16;
  localparam int DEF_AGE_BITS     = 32;

  localparam int ACTION_BITS = 2;
  localparam int IN_ID_BITS  = 16;
  localparam int SLOT_BITS   = 4;

  localparam logic [ACTION_BITS-1:0] ACT_STORE  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

  typedef struct packed {
    logic load;   // capture the request
    logic scan;   // read entry at scan index
    logic upd;    // apply the action, issue result
  } ipl_cmd_t;

endpackage

// ===== hw/rtl/id_pool_lru_table_unit.sv =====
// Top level of the ID pool LRU table: controller plus datapath.
// A request (in_action, in_object_id) is taken on a clock edge with start high and busy
// low. Each request gives exactly one result, shown for one cycle with out_valid high;
// the receiver cannot stall it. The ID and age stores have a single read port, so the
// search for a match and for the oldest entry visits one entry per cycle, followed by a
// drain state for the read latency and an update state; busy stays high until the update,
// so no new request is taken before then. The result strobe falls in the cycle where
// busy has just dropped. After reset the table is empty and needs no clearing pass.
module id_pool_lru_table_unit
  import ipl_pkg::*;
#(
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int ID_BITS      = DEF_ID_BITS,
  parameter int AGE_BITS     = DEF_AGE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_BITS-1:0] in_action,
  input  logic [IN_ID_BITS-1:0]  in_object_id,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [SLOT_BITS-1:0]   out_slot
);

  localparam int IDX_W = $clog2(POOL_ENTRIES);

  ipl_cmd_t         cmd;
  logic [IDX_W-1:0] scan_idx;

  ipl_ctrl #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .scan_idx(scan_idx)
  );

  ipl_dp #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .ID_BITS     (ID_BITS),
    .AGE_BITS    (AGE_BITS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .scan_idx    (scan_idx),
    .in_action   (in_action),
    .in_object_id(in_object_id),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_slot    (out_slot)
  );

endmodule

// ===== hw/rtl/ipl_ctrl.sv =====
// Controller: sequences capture, entry scan, drain and update for each request.
module ipl_ctrl
  import ipl_pkg::*;
#(
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int IDX_W        = $clog2(POOL_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output ipl_cmd_t         cmd,
  output logic [IDX_W-1:0] scan_idx
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_ENTRIES - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign scan_idx = idx_r;

endmodule

// ===== hw/rtl/ipl_dp.sv =====
// Datapath: ID and age stores, match and oldest search, update and result registers.
module ipl_dp
  import ipl_pkg::*;
#(
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int ID_BITS      = DEF_ID_BITS,
  parameter int AGE_BITS     = DEF_AGE_BITS,
  parameter int IDX_W        = $clog2(POOL_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ipl_cmd_t               cmd,
  input  logic [IDX_W-1:0]       scan_idx,
  input  logic [ACTION_BITS-1:0] in_action,
  input  logic [IN_ID_BITS-1:0]  in_object_id,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [SLOT_BITS-1:0]   out_slot
);

  logic [ID_BITS-1:0]  id_mem  [POOL_ENTRIES];
  logic [AGE_BITS-1:0] age_mem [POOL_ENTRIES];

  logic [POOL_ENTRIES-1:0] valid_r;
  logic [POOL_ENTRIES-1:0] age_ok_r;

  logic [ACTION_BITS-1:0] act_r;
  logic [ID_BITS-1:0]     id_r;
  logic [AGE_BITS-1:0]    cnt_r;

  logic [ID_BITS-1:0]  id_rd_r;
  logic [AGE_BITS-1:0] age_rd_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_en_r;

  logic                hit_r;
  logic [IDX_W-1:0]    pos_r;
  logic [IDX_W-1:0]    old_idx_r;
  logic [AGE_BITS-1:0] old_age_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [SLOT_BITS-1:0]   out_slot_r;

  logic [ID_BITS+IN_ID_BITS-1:0] id_ext;
  logic [AGE_BITS-1:0]           cur_age;
  logic                          cur_match;
  logic                          is_store;
  logic                          is_remove;
  logic [IDX_W-1:0]              tgt;
  logic [IDX_W-1:0]              res_idx;
  logic [IDX_W+SLOT_BITS-1:0]    res_ext;

  assign id_ext    = {{ID_BITS{1'b0}}, in_object_id};
  assign cur_age   = age_ok_r[cmp_idx_r] ? age_rd_r : '0;
  assign cur_match = valid_r[cmp_idx_r] && (id_rd_r == id_r);
  assign is_store  = (act_r == ACT_STORE);
  assign is_remove = (act_r == ACT_REMOVE);
  assign tgt       = hit_r ? pos_r : old_idx_r;
  assign res_idx   = is_store ? tgt : (hit_r ? pos_r : '0);
  assign res_ext   = {{SLOT_BITS{1'b0}}, res_idx};

  // stores: one read port at the scan index, one write port at update
  always_ff @(posedge clk) begin
    id_rd_r  <= id_mem[scan_idx];
    age_rd_r <= age_mem[scan_idx];
    if (cmd.upd && is_store) begin
      age_mem[tgt] <= cnt_r;
      if (!hit_r) begin
        id_mem[tgt] <= id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      age_ok_r    <= '0;
      cnt_r       <= AGE_BITS'(1);
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r    <= cmd.scan;
      out_valid_r <= cmd.upd;
      if (cmd.upd) begin
        if (is_store) begin
          valid_r[tgt]  <= 1'b1;
          age_ok_r[tgt] <= 1'b1;
          if (cnt_r != '1) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end else if (is_remove && hit_r) begin
          valid_r[pos_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx;
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= id_ext[ID_BITS-1:0];
      hit_r <= 1'b0;
      pos_r <= '0;
    end else if (cmp_en_r) begin
      if (!hit_r && cur_match) begin
        hit_r <= 1'b1;
        pos_r <= cmp_idx_r;
      end
      // oldest age, ties to the higher index
      if (cmp_idx_r == '0 || cur_age <= old_age_r) begin
        old_idx_r <= cmp_idx_r;
        old_age_r <= cur_age;
      end
    end
    if (cmd.upd) begin
      out_found_r <= hit_r;
      out_slot_r  <= res_ext[SLOT_BITS-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_slot  = out_slot_r;

endmodule

// ===== hw/rtl/ipl_chk.sv =====
// Port-level checker for the ID pool LRU table, bound to the top level.
module ipl_chk
  import ipl_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic                 out_found,
  input logic [SLOT_BITS-1:0] out_slot
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy did not rise");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!$isunknown(out_found) && !$isunknown(out_slot)))
    else $error("result fields unknown");

endmodule

bind id_pool_lru_table_unit ipl_chk u_ipl_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_found(out_found),
  .out_slot (out_slot)
);

// ===== tb/tb_id_pool_lru_table_unit.sv =====
// Self-checking testbench for the ID pool LRU table: directed and random requests.
`timescale 1ns / 100ps

module tb_id_pool_lru_table_unit;
  import ipl_pkg::*;

  localparam int ENTRIES   = DEF_POOL_ENTRIES;
  localparam int AGE_W     = DEF_AGE_BITS;
  localparam int RAND_REQS = 900;
  localparam int IDLE_MAX  = 2000;
  localparam int N_HOT     = 20;

  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] slot;
  } lru_reply_t;

  class lru_pool_tracker;
    logic [IN_ID_BITS-1:0] slot_id  [ENTRIES];
    bit                    slot_used[ENTRIES];
    logic [AGE_W-1:0]      slot_age [ENTRIES];
    logic [AGE_W-1:0]      age_now;
    lru_reply_t            expected_replies[$];
    int                    errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_id[i]   = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = '0;
      end
      age_now = AGE_W'(1);
      errors  = 0;
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(logic [ACTION_BITS-1:0] act, logic [IN_ID_BITS-1:0] id);
      bit         hit;
      int         pos;
      int         oldest;
      lru_reply_t r;
      hit    = 1'b0;
      pos    = 0;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!hit && slot_used[i] && slot_id[i] == id) begin
          hit = 1'b1;
          pos = i;
        end
        if (i > 0 && slot_age[i] <= slot_age[oldest]) oldest = i;
      end
      case (act)
        ACT_STORE: begin
          if (!hit) begin
            pos            = oldest;
            slot_id[pos]   = id;
            slot_used[pos] = 1'b1;
          end
          slot_age[pos] = age_now;
          if (age_now != '1) age_now = age_now + 1'b1;
        end
        ACT_REMOVE: begin
          if (hit) slot_used[pos] = 1'b0;
        end
        default: ;
      endcase
      if (act != ACT_STORE && !hit) pos = 0;
      r.found = hit;
      r.slot  = pos[SLOT_BITS-1:0];
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic found, logic [SLOT_BITS-1:0] slot);
      lru_reply_t r;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply found=%0d slot=%0d", found, slot));
        return;
      end
      r = expected_replies.pop_front();
      if (found !== r.found)
        report($sformatf("found %0d, expected %0d", found, r.found));
      if (slot !== r.slot)
        report($sformatf("slot %0d, expected %0d", slot, r.slot));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [ACTION_BITS-1:0] in_action;
  logic [IN_ID_BITS-1:0]  in_object_id;
  logic                   out_valid;
  logic                   out_found;
  logic [SLOT_BITS-1:0]   out_slot;

  lru_pool_tracker        tracker = new();
  logic [IN_ID_BITS-1:0]  hot_ids[N_HOT];
  int                     idle_cycles = 0;
  bit                     no_gaps = 1'b0;

  id_pool_lru_table_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_object_id (in_object_id),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_slot     (out_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_reply(out_found, out_slot);
    if (rst_n && start && !busy) tracker.note_request(in_action, in_object_id);
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ACTION_BITS-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return ACT_STORE;
    if (r < 75) return ACT_LOOKUP;
    if (r < 95) return ACT_REMOVE;
    return ~ACT_STORE;
  endfunction

  function automatic logic [IN_ID_BITS-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return hot_ids[$urandom_range(0, N_HOT - 1)];
    return IN_ID_BITS'($urandom_range(0, 16'hFFFF));
  endfunction

  // Lowers start for the gap (if any), then holds the request until taken.
  task automatic send_request(logic [ACTION_BITS-1:0] act, logic [IN_ID_BITS-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_action    <= ACTION_BITS'($urandom_range(0, 3));
        in_object_id <= IN_ID_BITS'($urandom_range(0, 16'hFFFF));
        @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_action    <= act;
    in_object_id <= id;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_STORE;
    in_object_id = '0;
    for (int i = 0; i < N_HOT; i++) hot_ids[i] = IN_ID_BITS'($urandom_range(0, 16'hFFFF));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, hits, misses, removal and refill, unused action
    send_request(ACT_STORE, 16'h0000);
    send_request(ACT_STORE, 16'hFFFF);
    send_request(ACT_STORE, 16'hFFFF);
    send_request(ACT_LOOKUP, 16'h0000);
    send_request(ACT_LOOKUP, 16'h1234);
    send_request(ACT_REMOVE, 16'hFFFF);
    send_request(ACT_REMOVE, 16'hFFFF);
    send_request(ACT_LOOKUP, 16'hFFFF);
    send_request(~ACT_STORE, 16'h0000);
    send_request(ACT_STORE, 16'hFFFF);
    for (int k = 0; k < 15; k++) send_request(ACT_STORE, IN_ID_BITS'(16'hA500 + k));

    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n % 300 == 150)
        for (int i = 0; i < N_HOT; i++) hot_ids[i] = IN_ID_BITS'($urandom_range(0, 16'hFFFF));
      send_request(pick_action(), pick_id());
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 3) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
